@@ src/hkt_pkg.sv @@
package hkt_pkg;

    localparam int SLOTS_DEFAULT = 1024;

    localparam int KEY_W     = 64;
    localparam int PAR_W     = 64;
    localparam int ATTR_W    = 32;
    localparam int NAME_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int IDX_OUT_W = 10;
    localparam int OCC_W     = 10;
    localparam int DATA_W    = PAR_W + ATTR_W + NAME_W;

    // Mix hash constants
    localparam int          MIX_SHIFT = 33;
    localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;

    // Front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic KIND_PUT = 1'b0;
    localparam logic KIND_GET = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_UPDATED   = 3'd1;
    localparam status_t ST_FOUND     = 3'd2;
    localparam status_t ST_NOT_FOUND = 3'd3;
    localparam status_t ST_FULL      = 3'd4;
    localparam status_t ST_ZERO_KEY  = 3'd5;

    // One classified request as it travels from front to back
    typedef struct packed {
        logic              kind;
        logic              zero_put;
        logic [KEY_W-1:0]  key;
        logic [PAR_W-1:0]  parent;
        logic [ATTR_W-1:0] attr;
        logic [NAME_W-1:0] name;
    } item_t;

    function automatic logic [63:0] xorshift(input logic [63:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

@@ src/hkt_ram.sv @@
module hkt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/hkt_front.sv @@
module hkt_front #(
    parameter int IDX_W = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          hold_in,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [hkt_pkg::KEY_W-1:0]     s_key,
    input  logic [hkt_pkg::PAR_W-1:0]     s_parent_ref,
    input  logic [hkt_pkg::ATTR_W-1:0]    s_attr_word,
    input  logic [hkt_pkg::NAME_W-1:0]    s_name_handle,
    output logic                          push,
    output hkt_pkg::item_t                push_item,
    output logic [IDX_W-1:0]              push_idx,
    input  logic                          q_full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL1 = 3'd1;
    localparam logic [2:0] F_ADD1 = 3'd2;
    localparam logic [2:0] F_MUL2 = 3'd3;
    localparam logic [2:0] F_ADD2 = 3'd4;

    logic [2:0]           state_reg, state_next;
    hkt_pkg::item_t       item_reg;
    logic [63:0]          v_reg;
    logic [63:0]          pp_ll_reg;
    logic [31:0]          pp_hl_reg, pp_lh_reg;
    logic [63:0]          cmul;
    logic [63:0]          pp_ll;
    logic [31:0]          pp_hl, pp_lh;
    logic [63:0]          prod;
    logic [63:0]          mixed;
    logic                 accept;

    assign s_ready = (state_reg == F_IDLE) && !hold_in;
    assign accept  = s_valid && s_ready;

    // Low 64 bits of v * c from three 32x32 partial products
    assign cmul  = (state_reg == F_MUL1) ? hkt_pkg::MIX_C1 : hkt_pkg::MIX_C2;
    assign pp_ll = 64'(v_reg[31:0]) * 64'(cmul[31:0]);
    assign pp_hl = v_reg[63:32] * cmul[31:0];
    assign pp_lh = v_reg[31:0] * cmul[63:32];
    assign prod  = pp_ll_reg + {pp_hl_reg + pp_lh_reg, 32'b0};
    assign mixed = hkt_pkg::xorshift(prod);

    assign push      = (state_reg == F_ADD2) && !q_full;
    assign push_item = item_reg;
    assign push_idx  = mixed[IDX_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_MUL1;
                end
            end
            F_MUL1:  state_next = F_ADD1;
            F_ADD1:  state_next = F_MUL2;
            F_MUL2:  state_next = F_ADD2;
            F_ADD2: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.kind     <= s_kind;
            item_reg.zero_put <= (s_kind == hkt_pkg::KIND_PUT) && (s_key == '0);
            item_reg.key      <= s_key;
            item_reg.parent   <= s_parent_ref;
            item_reg.attr     <= s_attr_word;
            item_reg.name     <= s_name_handle;
            v_reg             <= hkt_pkg::xorshift(s_key);
        end else if (state_reg == F_ADD1) begin
            v_reg <= mixed;
        end
        if (state_reg == F_MUL1 || state_reg == F_MUL2) begin
            pp_ll_reg <= pp_ll;
            pp_hl_reg <= pp_hl;
            pp_lh_reg <= pp_lh;
        end
    end

endmodule

@@ src/hkt_queue.sv @@
module hkt_queue #(
    parameter int IDX_W = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  hkt_pkg::item_t    push_item,
    input  logic [IDX_W-1:0]  push_idx,
    output logic              full,
    input  logic              pop,
    output hkt_pkg::item_t    pop_item,
    output logic [IDX_W-1:0]  pop_idx,
    output logic              empty
);

    hkt_pkg::item_t              item_mem_reg [hkt_pkg::QUEUE_DEPTH];
    logic [IDX_W-1:0]            idx_mem_reg  [hkt_pkg::QUEUE_DEPTH];
    logic [hkt_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [hkt_pkg::QCNT_W-1:0]  cnt_reg;

    assign full     = (cnt_reg == hkt_pkg::QCNT_W'(hkt_pkg::QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = item_mem_reg[rd_ptr_reg];
    assign pop_idx  = idx_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + hkt_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + hkt_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + hkt_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - hkt_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_mem_reg[wr_ptr_reg] <= push_item;
            idx_mem_reg[wr_ptr_reg]  <= push_idx;
        end
    end

endmodule

@@ src/hkt_back.sv @@
module hkt_back #(
    parameter int SLOTS = 1024,
    parameter int IDX_W = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    output logic                            clear_busy,
    input  logic                            q_empty,
    output logic                            pop,
    input  hkt_pkg::item_t                  pop_item,
    input  logic [IDX_W-1:0]                pop_idx,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hkt_pkg::STATUS_W-1:0]    m_status,
    output logic [hkt_pkg::PAR_W-1:0]       m_found_parent,
    output logic [hkt_pkg::ATTR_W-1:0]      m_found_attrs,
    output logic [hkt_pkg::NAME_W-1:0]      m_found_name,
    output logic [hkt_pkg::IDX_OUT_W-1:0]   m_slot_index,
    output logic [hkt_pkg::OCC_W-1:0]       m_occupancy
);

    localparam int SLOT_OUT_W = hkt_pkg::IDX_OUT_W;
    localparam int OCC_OUT_W  = hkt_pkg::OCC_W;
    localparam int HALF       = SLOTS / 2;

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_PROBE = 2'd2;

    logic [1:0]                   state_reg, state_next;
    hkt_pkg::item_t               cur_reg, cur_next;
    logic [IDX_W-1:0]             pos_reg, pos_next;
    logic [IDX_W-1:0]             total_reg, total_next;
    logic [IDX_W-1:0]             clr_reg, clr_next;

    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic [hkt_pkg::KEY_W-1:0]    key_rd_data;
    logic [hkt_pkg::DATA_W-1:0]   dat_rd_data;
    logic                         key_wr_en;
    logic [IDX_W-1:0]             key_wr_addr;
    logic [hkt_pkg::KEY_W-1:0]    key_wr_data;
    logic                         dat_wr_en;
    logic [hkt_pkg::DATA_W-1:0]   new_data;

    logic                         hit, empty_slot, table_full, out_free, load;
    hkt_pkg::status_t             res_status;
    logic [hkt_pkg::DATA_W-1:0]   res_data;
    logic [IDX_W-1:0]             res_idx;

    logic                         m_valid_reg;
    hkt_pkg::status_t             m_status_reg;
    logic [hkt_pkg::DATA_W-1:0]   m_data_reg;
    logic [SLOT_OUT_W-1:0]        m_slot_reg;
    logic [OCC_OUT_W-1:0]         m_occ_reg;

    hkt_ram #(
        .WIDTH (hkt_pkg::KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (key_rd_data)
    );

    hkt_ram #(
        .WIDTH (hkt_pkg::DATA_W),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .aclk    (aclk),
        .wr_en   (dat_wr_en),
        .wr_addr (pos_reg),
        .wr_data (new_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (dat_rd_data)
    );

    assign clear_busy = (state_reg == B_CLEAR);
    assign new_data   = {cur_reg.parent, cur_reg.attr, cur_reg.name};
    assign hit        = (key_rd_data == cur_reg.key);
    assign empty_slot = (key_rd_data == '0);
    assign table_full = (total_reg >= IDX_W'(HALF));
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        total_next  = total_reg;
        clr_next    = clr_reg;
        rd_en       = 1'b0;
        rd_addr     = pos_reg;
        key_wr_en   = 1'b0;
        key_wr_addr = pos_reg;
        key_wr_data = cur_reg.key;
        dat_wr_en   = 1'b0;
        pop         = 1'b0;
        load        = 1'b0;
        res_status  = hkt_pkg::ST_NOT_FOUND;
        res_data    = '0;
        res_idx     = pos_reg;
        case (state_reg)
            B_CLEAR: begin
                key_wr_en   = 1'b1;
                key_wr_addr = clr_reg;
                key_wr_data = '0;
                clr_next    = clr_reg + IDX_W'(1);
                if (clr_reg == '1) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!q_empty) begin
                    if (pop_item.zero_put) begin
                        if (out_free) begin
                            pop        = 1'b1;
                            load       = 1'b1;
                            res_status = hkt_pkg::ST_ZERO_KEY;
                            res_idx    = '0;
                        end
                    end else begin
                        pop        = 1'b1;
                        cur_next   = pop_item;
                        pos_next   = pop_idx;
                        rd_en      = 1'b1;
                        rd_addr    = pop_idx;
                        state_next = B_PROBE;
                    end
                end
            end
            B_PROBE: begin
                if (!hit && !empty_slot) begin
                    pos_next = pos_reg + IDX_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = pos_reg + IDX_W'(1);
                end else if (out_free) begin
                    load       = 1'b1;
                    state_next = B_IDLE;
                    if (cur_reg.kind == hkt_pkg::KIND_GET) begin
                        if (hit && !empty_slot) begin
                            res_status = hkt_pkg::ST_FOUND;
                            res_data   = dat_rd_data;
                        end
                    end else if (hit) begin
                        dat_wr_en  = 1'b1;
                        res_status = hkt_pkg::ST_UPDATED;
                        res_data   = new_data;
                    end else if (table_full) begin
                        res_status = hkt_pkg::ST_FULL;
                    end else begin
                        key_wr_en  = 1'b1;
                        dat_wr_en  = 1'b1;
                        total_next = total_reg + IDX_W'(1);
                        res_status = hkt_pkg::ST_INSERTED;
                        res_data   = new_data;
                    end
                end
            end
            default: state_next = B_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        pos_reg <= pos_next;
        if (load) begin
            m_status_reg <= res_status;
            m_data_reg   <= res_data;
            m_slot_reg   <= SLOT_OUT_W'(res_idx);
            m_occ_reg    <= OCC_OUT_W'(total_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_found_parent = m_data_reg[hkt_pkg::DATA_W-1 -: hkt_pkg::PAR_W];
    assign m_found_attrs  = m_data_reg[hkt_pkg::NAME_W +: hkt_pkg::ATTR_W];
    assign m_found_name   = m_data_reg[hkt_pkg::NAME_W-1:0];
    assign m_slot_index   = m_slot_reg;
    assign m_occupancy    = m_occ_reg;

endmodule

@@ src/hashed_key_table_linear_probe.sv @@
// Channel | Ports                                              | Direction
// --------+----------------------------------------------------+----------
// request | s_valid s_ready s_kind s_key s_parent_ref          | in
//         | s_attr_word s_name_handle                          |
// result  | m_valid m_ready m_status m_found_parent            | out
//         | m_found_attrs m_found_name m_slot_index m_occupancy|
//
// The hash front accepts a transaction, then runs four steps (MUL1, ADD1,
// MUL2, ADD2) of the shared 32x32 partial-product multiplier set, one
// transaction at a time; ADD2 waits while the queue is full. The probe back
// pops, then reads one slot after another through the key RAM read port; a
// put with key zero is answered without a probe. A two-entry queue lets the
// front hash the next key while the back probes. After reset the key RAM is
// swept to empty while s_ready is low. A result waits in the output register;
// the back stalls only when it must deliver and that register is still full.
module hashed_key_table_linear_probe #(
    parameter int SLOTS = hkt_pkg::SLOTS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [hkt_pkg::KEY_W-1:0]       s_key,
    input  logic [hkt_pkg::PAR_W-1:0]       s_parent_ref,
    input  logic [hkt_pkg::ATTR_W-1:0]      s_attr_word,
    input  logic [hkt_pkg::NAME_W-1:0]      s_name_handle,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hkt_pkg::STATUS_W-1:0]    m_status,
    output logic [hkt_pkg::PAR_W-1:0]       m_found_parent,
    output logic [hkt_pkg::ATTR_W-1:0]      m_found_attrs,
    output logic [hkt_pkg::NAME_W-1:0]      m_found_name,
    output logic [hkt_pkg::IDX_OUT_W-1:0]   m_slot_index,
    output logic [hkt_pkg::OCC_W-1:0]       m_occupancy
);

    // Slot index width; the user must keep SLOTS a power of two (not enforced here)
    localparam int IDX_W = $clog2(SLOTS);

    logic              clear_busy;
    logic              push, q_full, pop, q_empty;
    hkt_pkg::item_t    push_item, pop_item;
    logic [IDX_W-1:0]  push_idx, pop_idx;

    // Front: accept, flag a put of key zero, compute the start slot
    hkt_front #(
        .IDX_W (IDX_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .hold_in       (clear_busy),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key         (s_key),
        .s_parent_ref  (s_parent_ref),
        .s_attr_word   (s_attr_word),
        .s_name_handle (s_name_handle),
        .push          (push),
        .push_item     (push_item),
        .push_idx      (push_idx),
        .q_full        (q_full)
    );

    // Hold classified transactions between hashing and probing
    hkt_queue #(
        .IDX_W (IDX_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .push_idx  (push_idx),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .pop_idx   (pop_idx),
        .empty     (q_empty)
    );

    // Back: clear sweep, linear probe, insert or update, drive the result
    hkt_back #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .clear_busy     (clear_busy),
        .q_empty        (q_empty),
        .pop            (pop),
        .pop_item       (pop_item),
        .pop_idx        (pop_idx),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found_parent (m_found_parent),
        .m_found_attrs  (m_found_attrs),
        .m_found_name   (m_found_name),
        .m_slot_index   (m_slot_index),
        .m_occupancy    (m_occupancy)
    );

endmodule
